// ===== rtl/core/npe_pkg.sv =====
// ----------------------------------------------------------------------------
// npe_pkg
// Shared widths and operation codes for the next permutation engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package npe_pkg;

  // Field widths of a command beat and a result beat
  localparam int unsigned OP_W  = 1;
  localparam int unsigned POS_W = 6;
  localparam int unsigned VAL_W = 8;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD    = 1'b0;
  localparam logic [OP_W-1:0] OP_ADVANCE = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/core/npe_cmd_if.sv =====
// ----------------------------------------------------------------------------
// npe_cmd_if
// Command channel: load one element or advance to the next permutation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface npe_cmd_if;
  logic                               valid;
  logic                               ready;
  logic        [npe_pkg::OP_W-1:0]    operation;
  logic        [npe_pkg::POS_W-1:0]   position;
  logic signed [npe_pkg::VAL_W-1:0]   value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink   (input valid, input operation, input position, input value,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/npe_rsp_if.sv =====
// ----------------------------------------------------------------------------
// npe_rsp_if
// Result channel: one element of the new permutation per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface npe_rsp_if;
  logic                               valid;
  logic                               ready;
  logic        [npe_pkg::POS_W-1:0]   out_position;
  logic signed [npe_pkg::VAL_W-1:0]   out_value;
  logic                               last_element;
  logic                               had_next;

  modport source (output valid, output out_position, output out_value,
                  output last_element, output had_next, input ready);
  modport sink   (input valid, input out_position, input out_value,
                  input last_element, input had_next, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/next_permutation_engine_core.sv =====
// ----------------------------------------------------------------------------
// next_permutation_engine_core
// Holds COUNT signed elements and steps them to the next lexicographic
// permutation with one shared signed comparator under a small sequencer.
// ----------------------------------------------------------------------------
// Load beat: written to the sequence store while idle.
// Advance beat: scans for the descent, searches for the larger element, swaps,
//   reverses the suffix and emits COUNT result beats, each step through the
//   registered two-port read of the sequence store and the one comparator.
//   One command at a time: a new one is taken once the last beat is loaded.
// Reset clears the sequencer state and the result valid flag; the store is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module next_permutation_engine_core #(
  parameter int unsigned COUNT = 40
) (
  input  wire          clk,
  input  wire          rst,
  npe_cmd_if.sink      cmd,
  npe_rsp_if.source    rsp
);

  localparam int unsigned IW = $clog2(COUNT);
  localparam int unsigned VW = npe_pkg::VAL_W;
  localparam int unsigned PW = npe_pkg::POS_W;

  localparam logic [IW-1:0] IDX_LAST = IW'(COUNT - 1);

  // Sequencer state codes
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_CMP = 4'd2;
  localparam logic [3:0] S_SRCH_RD  = 4'd3;
  localparam logic [3:0] S_SRCH_CMP = 4'd4;
  localparam logic [3:0] S_SWAP_A   = 4'd5;
  localparam logic [3:0] S_SWAP_B   = 4'd6;
  localparam logic [3:0] S_REV_RD   = 4'd7;
  localparam logic [3:0] S_REV_WA   = 4'd8;
  localparam logic [3:0] S_REV_WB   = 4'd9;
  localparam logic [3:0] S_EMIT_RD  = 4'd10;
  localparam logic [3:0] S_EMIT_PUT = 4'd11;

  logic [3:0]    state, state_next;
  logic [IW-1:0] tail, tail_next;
  logic [IW-1:0] j, j_next;
  logic [IW-1:0] lo, lo_next;
  logic [IW-1:0] hi, hi_next;
  logic [IW-1:0] k, k_next;
  logic          had, had_next_r;

  // Sequence store with one write port and two registered read ports
  logic [VW-1:0] mem [COUNT];
  logic [VW-1:0] rdata_a, rdata_b;
  logic          rd_en;
  logic [IW-1:0] raddr_a, raddr_b;
  logic          wr_en;
  logic [IW-1:0] waddr;
  logic [VW-1:0] wdata;

  // Result register
  logic          ovalid;
  logic [PW-1:0] opos;
  logic [VW-1:0] oval;
  logic          olast;
  logic          ohad;
  logic          out_free;
  logic          out_load;

  logic          cmd_fire;
  logic          lt;

  assign cmd.ready = (state == S_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign out_free  = !ovalid || rsp.ready;

  // Shared signed compare: continue scanning while a >= b
  assign lt = $signed(rdata_a) < $signed(rdata_b);

  // Sequencer
  always_comb begin
    state_next = state;
    tail_next  = tail;
    j_next     = j;
    lo_next    = lo;
    hi_next    = hi;
    k_next     = k;
    had_next_r = had;
    rd_en      = 1'b0;
    raddr_a    = tail - 1'b1;
    raddr_b    = tail;
    wr_en      = 1'b0;
    waddr      = cmd.position[IW-1:0];
    wdata      = cmd.value;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (cmd_fire) begin
          if (cmd.operation == npe_pkg::OP_ADVANCE) begin
            tail_next  = IDX_LAST;
            state_next = S_SCAN_RD;
          end else if ({1'b0, cmd.position} < 7'(COUNT)) begin
            wr_en = 1'b1;
          end
        end
      end
      S_SCAN_RD: begin
        if (tail == '0) begin
          had_next_r = 1'b0;
          lo_next    = '0;
          hi_next    = IDX_LAST;
          state_next = S_REV_RD;
        end else begin
          rd_en      = 1'b1;
          state_next = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (lt) begin
          had_next_r = 1'b1;
          j_next     = IDX_LAST;
          state_next = S_SRCH_RD;
        end else begin
          tail_next  = tail - 1'b1;
          state_next = S_SCAN_RD;
        end
      end
      S_SRCH_RD: begin
        // The search always stops at tail at the latest
        rd_en      = 1'b1;
        raddr_b    = j;
        state_next = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (lt) begin
          state_next = S_SWAP_A;
        end else begin
          j_next     = j - 1'b1;
          state_next = S_SRCH_RD;
        end
      end
      S_SWAP_A: begin
        wr_en      = 1'b1;
        waddr      = tail - 1'b1;
        wdata      = rdata_b;
        state_next = S_SWAP_B;
      end
      S_SWAP_B: begin
        wr_en      = 1'b1;
        waddr      = j;
        wdata      = rdata_a;
        lo_next    = tail;
        hi_next    = IDX_LAST;
        state_next = S_REV_RD;
      end
      S_REV_RD: begin
        if (lo < hi) begin
          rd_en      = 1'b1;
          raddr_a    = lo;
          raddr_b    = hi;
          state_next = S_REV_WA;
        end else begin
          k_next     = '0;
          state_next = S_EMIT_RD;
        end
      end
      S_REV_WA: begin
        wr_en      = 1'b1;
        waddr      = lo;
        wdata      = rdata_b;
        state_next = S_REV_WB;
      end
      S_REV_WB: begin
        wr_en      = 1'b1;
        waddr      = hi;
        wdata      = rdata_a;
        lo_next    = lo + 1'b1;
        hi_next    = hi - 1'b1;
        state_next = S_REV_RD;
      end
      S_EMIT_RD: begin
        rd_en      = 1'b1;
        raddr_a    = k;
        state_next = S_EMIT_PUT;
      end
      S_EMIT_PUT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (k == IDX_LAST) begin
            state_next = S_IDLE;
          end else begin
            k_next     = k + 1'b1;
            state_next = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      had   <= 1'b0;
    end else begin
      state <= state_next;
      had   <= had_next_r;
    end
  end

  // Hold the index registers
  always_ff @(posedge clk) begin
    tail <= tail_next;
    j    <= j_next;
    lo   <= lo_next;
    hi   <= hi_next;
    k    <= k_next;
  end

  // Write and read the sequence store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

  // Hold a result beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (out_load) begin
      ovalid <= 1'b1;
    end else if (rsp.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      opos  <= PW'(k);
      oval  <= rdata_a;
      olast <= (k == IDX_LAST);
      ohad  <= had;
    end
  end

  assign rsp.valid        = ovalid;
  assign rsp.out_position = opos;
  assign rsp.out_value    = oval;
  assign rsp.last_element = olast;
  assign rsp.had_next     = ohad;

endmodule

`default_nettype wire

// ===== dv/next_permutation_engine_core_tb.sv =====
// ----------------------------------------------------------------------------
// next_permutation_engine_core_tb
// Self-checking bench for the next permutation engine. A shadow copy of the
// element store predicts every emitted permutation. Commands come from a
// prefilled backlog through a bursty driver. Result beats are checked field
// by field against the oldest prediction while the receiver stalls on
// shifting patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module next_permutation_engine_core_tb;
  import npe_pkg::*;

  localparam int unsigned ELEM_COUNT  = 40;
  localparam int unsigned RAND_ITEMS  = 380;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned TAIL_CYCLES = 8 * ELEM_COUNT;

  typedef struct {
    logic [OP_W-1:0]         operation;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
    bit                      hold_for_drain;
  } perm_cmd_t;

  typedef struct {
    logic [POS_W-1:0]        out_position;
    logic signed [VAL_W-1:0] out_value;
    logic                    last_element;
    logic                    had_next;
  } perm_beat_t;

  // Shapes of a full reload of the store
  typedef enum int {
    FILL_DESCENDING,
    FILL_EQUAL,
    FILL_NARROW,
    FILL_ASCENDING,
    FILL_RANDOM,
    FILL_STAIRS
  } fill_kind_t;

  // Receiver ready patterns
  typedef enum int {
    RX_ALWAYS,
    RX_MOSTLY,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_t;

  logic clk;
  logic rst;

  npe_cmd_if cmd_bus ();
  npe_rsp_if rsp_bus ();

  next_permutation_engine_core #(
    .COUNT(ELEM_COUNT)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_bus),
    .rsp(rsp_bus)
  );

  perm_cmd_t               perm_cmds_todo[$];
  perm_beat_t              perm_beats_due[$];
  logic signed [VAL_W-1:0] shadow_seq[ELEM_COUNT];
  perm_cmd_t               cmd_on_bus;
  int unsigned             error_count;
  int unsigned             cycle_count;
  int unsigned             burst_left;
  int unsigned             gap_left;
  rx_mode_t                rx_mode;
  int unsigned             rx_mode_left;
  int unsigned             rx_phase;

  // --------------------------------------------------------------------------
  // Backlog helpers
  // --------------------------------------------------------------------------
  task automatic add_load(input int unsigned pos, input int val,
                          input bit hold = 1'b0);
    perm_cmd_t c;
    c.operation      = OP_LOAD;
    c.position       = pos[POS_W-1:0];
    c.value          = VAL_W'(val);
    c.hold_for_drain = hold;
    perm_cmds_todo.push_back(c);
  endtask

  task automatic add_advance(input bit hold = 1'b0);
    perm_cmd_t c;
    c.operation      = OP_ADVANCE;
    c.position       = POS_W'($urandom_range(0, 63));
    c.value          = VAL_W'($urandom_range(0, 255));
    c.hold_for_drain = hold;
    perm_cmds_todo.push_back(c);
  endtask

  // Reload every element, starting at a random position and wrapping
  task automatic add_fill(input fill_kind_t kind, input bit hold);
    int unsigned             start;
    int unsigned             pos;
    int                      level;
    logic signed [VAL_W-1:0] val;
    start = $urandom_range(0, ELEM_COUNT - 1);
    level = int'($urandom_range(0, 255)) - 128;
    for (int unsigned k = 0; k < ELEM_COUNT; k++) begin
      pos = (start + k) % ELEM_COUNT;
      case (kind)
        FILL_DESCENDING: val = (pos == ELEM_COUNT - 1) ? VAL_W'(-128)
                                                       : VAL_W'(127 - 6 * int'(pos));
        FILL_EQUAL:      val = VAL_W'(level);
        FILL_NARROW:     val = VAL_W'(int'($urandom_range(0, 4)) - 2);
        FILL_ASCENDING:  val = VAL_W'(-128 + 6 * int'(pos));
        FILL_STAIRS:     val = VAL_W'(100 - 10 * int'(pos / 3));
        default:         val = VAL_W'($urandom_range(0, 255));
      endcase
      add_load(pos, val, hold && (k == 0));
    end
  endtask

  // --------------------------------------------------------------------------
  // Predictor: step the shadow store to its next lexicographic permutation
  // --------------------------------------------------------------------------
  task automatic predict_next_perm(output bit found);
    int                      tail;
    int                      j;
    int                      lo;
    int                      hi;
    logic signed [VAL_W-1:0] t;
    tail = ELEM_COUNT - 1;
    while (tail > 0 && shadow_seq[tail - 1] >= shadow_seq[tail]) tail--;
    if (tail > 0) begin
      j = ELEM_COUNT - 1;
      while (j > tail && shadow_seq[j] <= shadow_seq[tail - 1]) j--;
      t                    = shadow_seq[tail - 1];
      shadow_seq[tail - 1] = shadow_seq[j];
      shadow_seq[j]        = t;
    end
    lo = tail;
    hi = ELEM_COUNT - 1;
    while (lo < hi) begin
      t              = shadow_seq[lo];
      shadow_seq[lo] = shadow_seq[hi];
      shadow_seq[hi] = t;
      lo++;
      hi--;
    end
    found = (tail != 0);
  endtask

  // Apply one accepted command beat to the shadow store
  task automatic absorb_cmd(input perm_cmd_t c);
    bit         found;
    perm_beat_t b;
    if (c.operation == OP_LOAD) begin
      // out-of-range positions are dropped by the block
      if (c.position < ELEM_COUNT) shadow_seq[c.position] = c.value;
    end else begin
      predict_next_perm(found);
      for (int unsigned k = 0; k < ELEM_COUNT; k++) begin
        b.out_position = k[POS_W-1:0];
        b.out_value    = shadow_seq[k];
        b.last_element = (k == ELEM_COUNT - 1);
        b.had_next     = found;
        perm_beats_due.push_back(b);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock, reset and time-zero values
  // --------------------------------------------------------------------------
  initial begin
    clk               = 1'b0;
    rst               = 1'b1;
    cmd_bus.valid     = 1'b0;
    cmd_bus.operation = OP_LOAD;
    cmd_bus.position  = '0;
    cmd_bus.value     = '0;
    rsp_bus.ready     = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Command driver: bursts with random gaps, optional drain hold per beat
  // --------------------------------------------------------------------------
  initial begin
    burst_left = 0;
    gap_left   = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      cmd_bus.valid <= 1'b0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        absorb_cmd(cmd_on_bus);
      end
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          cmd_bus.valid <= 1'b0;
        end else if (perm_cmds_todo.size() != 0 &&
                     (!perm_cmds_todo[0].hold_for_drain || perm_beats_due.size() == 0)) begin
          cmd_on_bus = perm_cmds_todo.pop_front();
          cmd_bus.valid     <= 1'b1;
          cmd_bus.operation <= cmd_on_bus.operation;
          cmd_bus.position  <= cmd_on_bus.position;
          cmd_bus.value     <= cmd_on_bus.value;
          // close the burst and pick the next gap
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
          end else begin
            burst_left--;
          end
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor and receiver stall pattern
  // --------------------------------------------------------------------------
  initial begin
    rx_mode      = RX_ALWAYS;
    rx_mode_left = 0;
    rx_phase     = 0;
  end

  always @(posedge clk) begin
    perm_beat_t want;
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (perm_beats_due.size() == 0) begin
          $error("result beat with nothing expected: out_position %0d out_value %0d",
                 rsp_bus.out_position, rsp_bus.out_value);
          error_count++;
        end else begin
          want = perm_beats_due.pop_front();
          if (rsp_bus.out_position !== want.out_position) begin
            $error("out_position: expected %0d, actual %0d", want.out_position,
                   rsp_bus.out_position);
            error_count++;
          end
          if (rsp_bus.out_value !== want.out_value) begin
            $error("out_value: expected %0d, actual %0d", want.out_value, rsp_bus.out_value);
            error_count++;
          end
          if (rsp_bus.last_element !== want.last_element) begin
            $error("last_element: expected %0b, actual %0b", want.last_element,
                   rsp_bus.last_element);
            error_count++;
          end
          if (rsp_bus.had_next !== want.had_next) begin
            $error("had_next: expected %0b, actual %0b", want.had_next, rsp_bus.had_next);
            error_count++;
          end
        end
      end
      // switch stall pattern now and then
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(32, 400);
      end else begin
        rx_mode_left--;
      end
      rx_phase++;
      case (rx_mode)
        RX_ALWAYS:   rsp_bus.ready <= 1'b1;
        RX_MOSTLY:   rsp_bus.ready <= ($urandom_range(0, 9) < 7);
        RX_SPARSE:   rsp_bus.ready <= ($urandom_range(0, 3) == 0);
        default:     rsp_bus.ready <= (rx_phase % 3 == 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int unsigned rand_items;
    int unsigned seq_idx;
    int unsigned pick;
    int unsigned n;
    bit          hold;
    error_count = 0;

    // Preload a strictly descending store: the last permutation
    add_fill(FILL_DESCENDING, 1'b0);
    // Loads past the end of the store are dropped
    add_load(63, 0);
    add_load(40, -1);
    // Wrap to ascending, then a plain step
    add_advance();
    add_advance();
    // Extreme values at both ends
    add_load(0, 127);
    add_advance();
    add_load(ELEM_COUNT - 1, -128);
    add_advance();
    add_load(20, -1);
    add_load(21, 0);
    add_advance(1'b1);
    add_advance();
    add_advance();

    // Random part: load-then-advance sequences, full reloads, advance runs and dropped loads
    rand_items = 0;
    seq_idx    = 0;
    while (rand_items < RAND_ITEMS) begin
      hold = (seq_idx % 12 == 11);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        n = $urandom_range(1, 4);
        for (int unsigned k = 0; k < n; k++) begin
          if ($urandom_range(0, 4) == 0) begin
            add_load($urandom_range(0, ELEM_COUNT - 1), ($urandom_range(0, 1) != 0) ? 127 : -128,
                     hold && (k == 0));
          end else begin
            add_load($urandom_range(0, ELEM_COUNT - 1), VAL_W'($urandom_range(0, 255)),
                     hold && (k == 0));
          end
        end
        rand_items += n;
        n = $urandom_range(1, 3);
        for (int unsigned k = 0; k < n; k++) add_advance();
        rand_items += n;
      end else if (pick < 55) begin
        add_fill(fill_kind_t'($urandom_range(0, 5)), hold);
        rand_items += ELEM_COUNT;
        n = $urandom_range(1, 3);
        for (int unsigned k = 0; k < n; k++) add_advance();
        rand_items += n;
      end else if (pick < 85) begin
        n = $urandom_range(2, 6);
        for (int unsigned k = 0; k < n; k++) add_advance(hold && (k == 0));
        rand_items += n;
      end else begin
        // noise: dropped loads past the end of the store
        n = $urandom_range(1, 3);
        for (int unsigned k = 0; k < n; k++) begin
          add_load($urandom_range(ELEM_COUNT, 63), VAL_W'($urandom_range(0, 255)),
                   hold && (k == 0));
        end
      end
      seq_idx++;
    end

    // Wait for the backlog to drain and every predicted beat to arrive
    @(negedge rst);
    while (perm_cmds_todo.size() != 0 || cmd_bus.valid || perm_beats_due.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/npe_pkg.sv
rtl/core/npe_cmd_if.sv
rtl/core/npe_rsp_if.sv
rtl/core/next_permutation_engine_core.sv
dv/next_permutation_engine_core_tb.sv
